@@ rtl/core/doc_pkg.sv @@
// Shared types and constants for the door opener controller.
package doc_pkg;

    localparam int CNT_W  = 8;
    localparam int TRV_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int NUM_IN = 5;

    typedef enum logic [3:0] {
        M_STARTING   = 4'd0,
        M_PRELOCKED  = 4'd1,
        M_LOCKED     = 4'd2,
        M_CODE1      = 4'd3,
        M_CODE2      = 4'd4,
        M_CODE3      = 4'd5,
        M_PREIDLE    = 4'd6,
        M_IDLE       = 4'd7,
        M_CLOSED     = 4'd8,
        M_PREOPENING = 4'd9,
        M_OPENING    = 4'd10,
        M_OPEN       = 4'd11,
        M_PRECLOSING = 4'd12,
        M_CLOSING    = 4'd13
    } mode_t;

    typedef enum logic [1:0] {
        MOT_STOP  = 2'd0,
        MOT_OPEN  = 2'd1,
        MOT_CLOSE = 2'd2
    } motor_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PRESS_THRESHOLD = 3'd0,
        REG_DEBOUNCE_WRAP   = 3'd1,
        REG_TRAVEL_TIMEOUT  = 3'd2,
        REG_TIMEOUT_WRAP    = 3'd3
    } reg_idx_t;

    // control order
    localparam int PR_OPEN   = 0;
    localparam int PR_CLOSE  = 1;
    localparam int PR_OLIM   = 2;
    localparam int PR_CLIM   = 3;
    localparam int PR_EMERG  = 4;

    localparam logic [2:0] LED_NONE = 3'b000;
    localparam logic [2:0] LED_O    = 3'b001;
    localparam logic [2:0] LED_C    = 3'b010;
    localparam logic [2:0] LED_L    = 3'b100;
    localparam logic [2:0] LED_ALL  = 3'b111;

endpackage

@@ rtl/core/doc_in_if.sv @@
// Input tick channel: five control levels.
interface doc_in_if;
    logic valid;
    logic ready;
    logic open_button;
    logic close_button;
    logic open_limit;
    logic closed_limit;
    logic emergency_button;

    modport source (output valid, open_button, close_button, open_limit, closed_limit,
                    emergency_button, input ready);
    modport sink (input valid, open_button, close_button, open_limit, closed_limit,
                  emergency_button, output ready);
endinterface

@@ rtl/core/doc_out_if.sv @@
// Result channel: motor command, LED levels and mode.
interface doc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] motor_cmd;
    logic       led_open;
    logic       led_close;
    logic       led_locked;
    logic [3:0] mode;

    modport source (output valid, motor_cmd, led_open, led_close, led_locked, mode,
                    input ready);
    modport sink (input valid, motor_cmd, led_open, led_close, led_locked, mode,
                  output ready);
endinterface

@@ rtl/core/door_opener_controller.sv @@
// Door opener controller top level: debounce, travel timer and mode machine.
// Latency: the result of a tick is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while result_out is ready; the result register frees as it is taken.
// The debounce counters, travel counter and mode machine update when a tick is accepted.
// Reset: mode starting, counters zero, motor stopped, all LEDs on, registers at defaults.
module door_opener_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    doc_in_if.sink                      tick_in,
    doc_out_if.source                   result_out,
    input  logic                        cfg_we,
    input  logic [doc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [doc_pkg::CFG_W-1:0]   cfg_data
);
    import doc_pkg::*;

    logic [CNT_W-1:0] press_threshold_reg;
    logic [CNT_W-1:0] debounce_wrap_reg;
    logic [TRV_W-1:0] travel_timeout_reg;
    logic [TRV_W-1:0] timeout_wrap_reg;

    mode_t            mode_reg,    mode_next;
    motor_t           motor_reg,   motor_next;
    logic [2:0]       led_reg,     led_next;
    logic [TRV_W-1:0] travel_reg,  travel_next;
    logic [TRV_W-1:0] travel_upd;
    logic [TRV_W-1:0] travel_inc;
    logic             out_valid_reg;

    logic             accept;
    logic [NUM_IN-1:0] level;
    logic [NUM_IN-1:0] pr;

    assign tick_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = tick_in.valid && tick_in.ready;

    assign level[PR_OPEN]  = tick_in.open_button;
    assign level[PR_CLOSE] = tick_in.close_button;
    assign level[PR_OLIM]  = tick_in.open_limit;
    assign level[PR_CLIM]  = tick_in.closed_limit;
    assign level[PR_EMERG] = tick_in.emergency_button;

    for (genvar g = 0; g < NUM_IN; g++)
    begin : g_deb
        doc_debounce u_deb (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (accept),
            .level     (level[g]),
            .wrap      (debounce_wrap_reg),
            .threshold (press_threshold_reg),
            .pressed   (pr[g])
        );
    end

    always_comb
    begin
        travel_inc = travel_reg + 1'b1;
        if (mode_reg == M_OPENING || mode_reg == M_CLOSING)
        begin
            travel_upd = (travel_inc > timeout_wrap_reg) ? '0 : travel_inc;
        end
        else if (travel_reg != '0)
        begin
            travel_upd = travel_reg - 1'b1;
        end
        else
        begin
            travel_upd = travel_reg;
        end
    end

    // mode machine step; later rules override earlier ones
    always_comb
    begin
        mode_next   = mode_reg;
        motor_next  = motor_reg;
        led_next    = led_reg;
        travel_next = travel_upd;
        case (mode_reg)
            M_STARTING:
            begin
                led_next  = LED_L;
                mode_next = M_LOCKED;
            end
            M_PRELOCKED:
            begin
                mode_next = M_LOCKED;
            end
            M_LOCKED:
            begin
                motor_next = MOT_STOP;
                if (pr[PR_OPEN])
                begin
                    led_next  = LED_O;
                    mode_next = M_CODE1;
                end
            end
            M_CODE1:
            begin
                if (pr[PR_CLOSE])
                begin
                    led_next  = LED_C;
                    mode_next = M_CODE2;
                end
            end
            M_CODE2:
            begin
                if (pr[PR_OPEN])
                begin
                    led_next  = LED_L;
                    mode_next = M_CODE3;
                end
            end
            M_CODE3:
            begin
                if (pr[PR_EMERG])
                begin
                    led_next  = LED_NONE;
                    mode_next = M_PREIDLE;
                end
            end
            M_PREIDLE:
            begin
                led_next  = LED_O | LED_L;
                mode_next = M_IDLE;
            end
            M_IDLE:
            begin
                if (pr[PR_OLIM])
                begin
                    led_next  = led_next | LED_O;
                    mode_next = M_OPEN;
                end
                if (pr[PR_CLIM])
                begin
                    led_next  = led_next | LED_C;
                    mode_next = M_CLOSED;
                end
                if (pr[PR_OPEN])
                begin
                    mode_next = M_PREOPENING;
                end
                if (pr[PR_CLOSE])
                begin
                    mode_next = M_PRECLOSING;
                end
            end
            M_CLOSED:
            begin
                if (pr[PR_OPEN])
                begin
                    mode_next = M_PREOPENING;
                end
                if (pr[PR_EMERG])
                begin
                    led_next  = led_reg | LED_L;
                    mode_next = M_LOCKED;
                end
            end
            M_PREOPENING:
            begin
                led_next  = LED_NONE;
                mode_next = M_OPENING;
            end
            M_OPENING:
            begin
                if (travel_upd > travel_timeout_reg)
                begin
                    travel_next = '0;
                    mode_next   = M_LOCKED;
                end
                motor_next = MOT_OPEN;
                if (pr[PR_EMERG])
                begin
                    led_next    = led_reg | LED_L;
                    travel_next = '0;
                    mode_next   = M_LOCKED;
                end
                if (pr[PR_OLIM])
                begin
                    motor_next  = MOT_STOP;
                    led_next    = LED_O;
                    travel_next = '0;
                    mode_next   = M_OPEN;
                end
            end
            M_OPEN:
            begin
                if (pr[PR_CLOSE])
                begin
                    mode_next = M_PRECLOSING;
                end
                if (pr[PR_EMERG])
                begin
                    mode_next = M_LOCKED;
                end
            end
            M_PRECLOSING:
            begin
                led_next  = LED_NONE;
                mode_next = M_CLOSING;
            end
            M_CLOSING:
            begin
                if (travel_upd > travel_timeout_reg)
                begin
                    travel_next = '0;
                    mode_next   = M_LOCKED;
                end
                motor_next = MOT_CLOSE;
                if (pr[PR_EMERG])
                begin
                    travel_next = '0;
                    mode_next   = M_LOCKED;
                end
                if (pr[PR_CLIM])
                begin
                    motor_next  = MOT_STOP;
                    led_next    = LED_C;
                    travel_next = '0;
                    mode_next   = M_CLOSED;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_STARTING;
            motor_reg     <= MOT_STOP;
            led_reg       <= LED_ALL;
            travel_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                motor_reg  <= motor_next;
                led_reg    <= led_next;
                travel_reg <= travel_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_threshold_reg <= CNT_W'(30);
            debounce_wrap_reg   <= CNT_W'(50);
            travel_timeout_reg  <= TRV_W'(10000);
            timeout_wrap_reg    <= TRV_W'(15000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESS_THRESHOLD: press_threshold_reg <= cfg_data[CNT_W-1:0];
                REG_DEBOUNCE_WRAP:   debounce_wrap_reg   <= cfg_data[CNT_W-1:0];
                REG_TRAVEL_TIMEOUT:  travel_timeout_reg  <= cfg_data[TRV_W-1:0];
                REG_TIMEOUT_WRAP:    timeout_wrap_reg    <= cfg_data[TRV_W-1:0];
                default:             ;
            endcase
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.motor_cmd  = motor_reg;
    assign result_out.led_open   = led_reg[0];
    assign result_out.led_close  = led_reg[1];
    assign result_out.led_locked = led_reg[2];
    assign result_out.mode       = mode_reg;
endmodule

@@ rtl/core/doc_debounce.sv @@
// One debounce counter with wrap and press detection.
module doc_debounce (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       level,
    input  logic [doc_pkg::CNT_W-1:0]  wrap,
    input  logic [doc_pkg::CNT_W-1:0]  threshold,
    output logic                       pressed
);
    import doc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;

    always_comb
    begin
        count_inc = count_reg + 1'b1;
        if (level)
        begin
            count_next = (count_inc > wrap) ? '0 : count_inc;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign pressed = level && (count_next > threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (en)
        begin
            count_reg <= count_next;
        end
    end
endmodule
